@@ src/gbnm_pkg.sv @@
// Shared constants, request and reply codes, and divider types for the glyph brightness block.
`timescale 1ns / 1ps
`default_nettype none

package gbnm_pkg;

   // Payload widths.
   localparam int REQ_TYPE_W = 2;
   localparam int CODE_W     = 7;
   localparam int LEVEL_W    = 8;
   localparam int SUM_W      = 24;
   localparam int COUNT_W    = 17;

   // Table size default and fixed scaling limits.
   localparam int DEFAULT_TABLE_DEPTH = 128;
   localparam int MAX_LEVEL           = 255;
   localparam int MAX_PIXELS          = 65536;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR     = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PIXEL     = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_NORMALIZE = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY     = 2'd3;

   // Reply kinds.
   localparam logic RSP_QUERY     = 1'b0;
   localparam logic RSP_NORMALIZE = 1'b1;

   // Divider operand widths: the dividend covers the pixel sum, the divisor the count.
   localparam int DIV_DIVIDEND_W = SUM_W;
   localparam int DIV_DIVISOR_W  = COUNT_W;

   // Start command for the shared divider.
   typedef struct packed {
      logic                      start;
      logic [DIV_DIVIDEND_W-1:0] dividend;
      logic [DIV_DIVISOR_W-1:0]  divisor;
   } div_req_type;

   // Status and result of the shared divider.
   typedef struct packed {
      logic                      busy;
      logic                      done;
      logic [DIV_DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ src/gbnm_req_if.sv @@
// Request channel: valid/ready handshake with the request payload.
`timescale 1ns / 1ps
`default_nettype none

interface gbnm_req_if import gbnm_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [CODE_W-1:0]     symbol_code;
   logic [LEVEL_W-1:0]    pixel_value;
   logic                  last_pixel;
   logic [LEVEL_W-1:0]    target_level;

   modport source (
      output valid, req_type, symbol_code, pixel_value, last_pixel, target_level,
      input  ready
   );

   modport sink (
      input  valid, req_type, symbol_code, pixel_value, last_pixel, target_level,
      output ready
   );

endinterface

`default_nettype wire

@@ src/gbnm_rsp_if.sv @@
// Reply channel: valid/ready handshake with the reply payload.
`timescale 1ns / 1ps
`default_nettype none

interface gbnm_rsp_if import gbnm_pkg::*; ();

   logic              valid;
   logic              ready;
   logic              reply_kind;
   logic [CODE_W-1:0] match_symbol;
   logic              table_empty;
   logic              flat_range;

   modport source (
      output valid, reply_kind, match_symbol, table_empty, flat_range,
      input  ready
   );

   modport sink (
      input  valid, reply_kind, match_symbol, table_empty, flat_range,
      output ready
   );

endinterface

`default_nettype wire

@@ src/gbnm_div.sv @@
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module gbnm_div import gbnm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(DIV_DIVIDEND_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_DIVIDEND_W - 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          step_ff, step_in;
   logic [DIV_DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIV_DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIV_DIVISOR_W-1:0]  divisor_ff, divisor_in;

   logic [DIV_DIVISOR_W:0]    rem_shift;
   logic [DIV_DIVISOR_W:0]    rem_diff;
   logic                      fits;

   // One trial subtraction: shift in the next dividend bit and subtract if it fits.
   always_comb begin
      rem_shift = {rem_ff, quot_ff[DIV_DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = (rem_shift >= {1'b0, divisor_ff});
   end

   // Next state: load on start, then step until the last quotient bit is in.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_DIVIDEND_W-2:0], fits};
         rem_in  = fits ? rem_diff[DIV_DIVISOR_W-1:0] : rem_shift[DIV_DIVISOR_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         step_ff    <= step_in;
         quot_ff    <= quot_in;
         rem_ff     <= rem_in;
         divisor_ff <= divisor_in;
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   // A new division is only started on an idle unit.
   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   // The done pulse follows the last step directly.
   a_done_after_step : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !div_req.start && step_ff == LAST_STEP) |=> (done_ff && !busy_ff))
      else $error("divider missed its done pulse");

   // Done lasts a single cycle.
   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

@@ src/glyph_brightness_nearest_match.sv @@
// Glyph brightness table with nearest-level lookup, one request at a time.
// Clear and plain pixel requests are handled in the idle state; a last pixel waits on a 24-step divide.
// Query: the table is scanned one entry per cycle, then the result is formed and handed to the reply.
// Normalize: the same scan, then each valid entry is rescaled through the divider and each invalid one skipped.
// The shared divider serves both the per-entry rescale and the last-pixel mean; ready is high only between requests.
// Reset clears all valid bits and the pixel accumulator at once; table contents are undefined.
`timescale 1ns / 1ps
`default_nettype none

module glyph_brightness_nearest_match import gbnm_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   gbnm_req_if.sink    req_ch,
   gbnm_rsp_if.source  rsp_ch
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN_DIV,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_EVAL,
      ST_NRM_RD,
      ST_NRM_MUL,
      ST_NRM_DIV,
      ST_REPLY
   } state_type;

   state_type               state_ff, state_in;
   logic                    is_query_ff, is_query_in;
   logic [LEVEL_W-1:0]      target_ff, target_in;
   logic [IDX_W-1:0]        code_ff, code_in;
   logic                    code_ok_ff, code_ok_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    rd_live_ff, rd_live_in;
   logic                    any_ff, any_in;
   logic [LEVEL_W-1:0]      lo_ff, lo_in;
   logic [LEVEL_W-1:0]      hi_ff, hi_in;
   logic [LEVEL_W-1:0]      best_ff, best_in;
   logic [IDX_W-1:0]        sym_ff, sym_in;
   logic                    res_empty_ff, res_empty_in;
   logic                    res_flat_ff, res_flat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [CODE_W-1:0]       rsp_sym_ff, rsp_sym_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_flat_ff, rsp_flat_in;

   logic [LEVEL_W-1:0]      level_mem [TABLE_DEPTH];
   logic [LEVEL_W-1:0]      rd_data_ff;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_idx;
   logic [LEVEL_W-1:0]      wr_data;

   logic                    req_xfer;
   logic [SUM_W-1:0]        pix_sum;
   logic [COUNT_W-1:0]      pix_count;
   logic [LEVEL_W-1:0]      level_gap;
   logic [2*LEVEL_W-1:0]    scaled;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // Pixel accumulation; samples past the pixel limit are dropped.
   always_comb begin
      pix_sum   = sum_ff;
      pix_count = count_ff;
      if (count_ff < COUNT_W'(MAX_PIXELS)) begin
         pix_sum   = sum_ff + SUM_W'(req_ch.pixel_value);
         pix_count = count_ff + 1'b1;
      end
   end

   // Distance of the scanned level from the query target.
   always_comb begin
      level_gap = (target_ff > rd_data_ff) ? (target_ff - rd_data_ff)
                                           : (rd_data_ff - target_ff);
   end

   // Offset from the minimum scaled to the full level range; the divider registers it.
   assign scaled = (2*LEVEL_W)'(rd_data_ff - lo_ff) * (2*LEVEL_W)'(MAX_LEVEL);

   // Divider start: mean on a last pixel, rescale of one entry during normalize.
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = DIV_DIVIDEND_W'(scaled);
      div_req.divisor  = DIV_DIVISOR_W'(hi_ff - lo_ff);
      if (state_ff == ST_NRM_MUL) begin
         div_req.start = 1'b1;
      end else if (req_xfer && req_ch.req_type == REQ_PIXEL && req_ch.last_pixel) begin
         div_req.start    = 1'b1;
         div_req.dividend = pix_sum;
         div_req.divisor  = pix_count;
      end
   end

   gbnm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Table write port: a finished mean or a rescaled entry.
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = scan_idx_ff;
      wr_data = div_rsp.quotient[LEVEL_W-1:0];
      if (state_ff == ST_MEAN_DIV && div_rsp.done) begin
         wr_en  = code_ok_ff;
         wr_idx = code_ff;
      end else if (state_ff == ST_NRM_DIV && div_rsp.done) begin
         wr_en = 1'b1;
      end
   end

   // Level memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         level_mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= level_mem[scan_idx_ff];
      rd_idx_ff  <= scan_idx_ff;
   end

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      is_query_in  = is_query_ff;
      target_in    = target_ff;
      code_in      = code_ff;
      code_ok_in   = code_ok_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      scan_idx_in  = scan_idx_ff;
      rd_live_in   = (state_ff == ST_SCAN) && valid_ff[scan_idx_ff];
      any_in       = any_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      best_in      = best_ff;
      sym_in       = sym_ff;
      res_empty_in = res_empty_ff;
      res_flat_in  = res_flat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_flat_in  = rsp_flat_ff;

      // Fold the entry read in the previous cycle into min, max and best match.
      if (rd_live_ff) begin
         any_in = 1'b1;
         if (!any_ff) begin
            lo_in  = rd_data_ff;
            hi_in  = rd_data_ff;
            sym_in = rd_idx_ff;
         end else begin
            if (rd_data_ff < lo_ff) lo_in = rd_data_ff;
            if (rd_data_ff > hi_ff) hi_in = rd_data_ff;
         end
         if (level_gap < best_ff) begin
            best_in = level_gap;
            sym_in  = rd_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               is_query_in = (req_ch.req_type == REQ_QUERY);
               target_in   = req_ch.target_level;
               scan_idx_in = '0;
               any_in      = 1'b0;
               best_in     = LEVEL_W'(MAX_LEVEL);
               sym_in      = '0;
               case (req_ch.req_type)
                  REQ_CLEAR: begin
                     valid_in = '0;
                  end
                  REQ_PIXEL: begin
                     sum_in   = pix_sum;
                     count_in = pix_count;
                     if (req_ch.last_pixel) begin
                        code_in    = IDX_W'(req_ch.symbol_code);
                        code_ok_in = (32'(req_ch.symbol_code) < 32'(TABLE_DEPTH));
                        sum_in     = '0;
                        count_in   = '0;
                        state_in   = ST_MEAN_DIV;
                     end
                  end
                  default: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_MEAN_DIV: begin
            if (div_rsp.done) begin
               if (code_ok_ff) valid_in[code_ff] = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_ff == LAST_IDX) begin
               scan_idx_in = '0;
               state_in    = ST_SCAN_TAIL;
            end
         end
         ST_SCAN_TAIL: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            res_empty_in = !any_ff;
            res_flat_in  = 1'b0;
            scan_idx_in  = '0;
            if (is_query_ff || !any_ff) begin
               state_in = ST_REPLY;
            end else if (hi_ff == lo_ff) begin
               res_flat_in = 1'b1;
               state_in    = ST_REPLY;
            end else begin
               state_in = ST_NRM_RD;
            end
         end
         ST_NRM_RD: begin
            if (valid_ff[scan_idx_ff]) begin
               state_in = ST_NRM_MUL;
            end else if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_REPLY;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_NRM_MUL: begin
            state_in = ST_NRM_DIV;
         end
         ST_NRM_DIV: begin
            if (div_rsp.done) begin
               if (scan_idx_ff == LAST_IDX) begin
                  state_in = ST_REPLY;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
                  state_in    = ST_NRM_RD;
               end
            end
         end
         ST_REPLY: begin
            // Hand the reply to the output register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = is_query_ff ? RSP_QUERY : RSP_NORMALIZE;
               rsp_sym_in   = is_query_ff ? CODE_W'(sym_ff) : '0;
               rsp_empty_in = res_empty_ff;
               rsp_flat_in  = res_flat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
         is_query_ff  <= is_query_in;
         target_ff    <= target_in;
         code_ff      <= code_in;
         code_ok_ff   <= code_ok_in;
         scan_idx_ff  <= scan_idx_in;
         any_ff       <= any_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         best_ff      <= best_in;
         sym_ff       <= sym_in;
         res_empty_ff <= res_empty_in;
         res_flat_ff  <= res_flat_in;
         rsp_kind_ff  <= rsp_kind_in;
         rsp_sym_ff   <= rsp_sym_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_flat_ff  <= rsp_flat_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.reply_kind   = rsp_kind_ff;
   assign rsp_ch.match_symbol = rsp_sym_ff;
   assign rsp_ch.table_empty  = rsp_empty_ff;
   assign rsp_ch.flat_range   = rsp_flat_ff;

   // While the sequencer waits on a division, the divider is running or just finished.
   a_div_wait : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MEAN_DIV || state_ff == ST_NRM_DIV) |-> (div_rsp.busy || div_rsp.done))
      else $error("sequencer waits on an idle divider");

   // A clear transfer leaves no valid entry behind.
   a_clear_all : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.req_type == REQ_CLEAR) |=> (valid_ff == '0))
      else $error("valid bits survived a clear");

   // The table is written only with a finished quotient.
   a_write_source : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (div_rsp.done && (state_ff == ST_MEAN_DIV || state_ff == ST_NRM_DIV)))
      else $error("table written outside a division result");

   // A reply never flags an empty table and a flat range together, and queries are never flat.
   a_reply_flags : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!(rsp_flat_ff && rsp_empty_ff) &&
                        !(rsp_kind_ff == RSP_QUERY && rsp_flat_ff)))
      else $error("inconsistent reply flags");

   // New requests are taken only with the divider at rest.
   a_ready_div_idle : assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !div_rsp.busy)
      else $error("request accepted during a division");

endmodule

`default_nettype wire

@@ test/tb_glyph_brightness_nearest_match.sv @@
// Self-checking testbench for the glyph brightness table with nearest-level lookup.
`timescale 1ns / 1ps

module tb_glyph_brightness_nearest_match;
   import gbnm_pkg::*;

   localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 300;

   // One request as offered on the request channel.
   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      logic [CODE_W-1:0]     code;
      logic [LEVEL_W-1:0]    pixel;
      logic                  is_last;
      logic [LEVEL_W-1:0]    target;
   } glyph_req_type;

   // One reply as seen on the reply channel.
   typedef struct packed {
      logic              kind;
      logic [CODE_W-1:0] symbol;
      logic              empty;
      logic              flat;
   } glyph_reply_type;

   logic clock = 1'b0;
   logic reset;

   gbnm_req_if req_ch ();
   gbnm_rsp_if rsp_ch ();

   glyph_brightness_nearest_match dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Mirror of the block's table and pixel accumulator.
   logic [LEVEL_W-1:0] levels [TABLE_DEPTH];
   bit                 occupied [TABLE_DEPTH];
   logic [SUM_W-1:0]   acc_sum;
   logic [COUNT_W-1:0] acc_count;

   glyph_req_type   pending_reqs [$];
   glyph_reply_type expected_replies [$];

   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned reqs_queued;
   int unsigned sent_count;
   int unsigned hold_at;
   int unsigned hold_cycles_left;
   bit          hold_used;
   bit          req_taken;
   int unsigned error_count;
   int unsigned cycle_count;

   // Update the mirrored table for one accepted request and queue any reply it causes.
   function automatic void apply_request(glyph_req_type r);
      int              lo;
      int              hi;
      int              d;
      int              best;
      int unsigned     i;
      bit              found;
      glyph_reply_type rep;
      rep = '0;
      lo = 0;
      hi = 0;
      found = 1'b0;
      case (r.kind)
         REQ_CLEAR: begin
            for (i = 0; i < TABLE_DEPTH; i++) occupied[i] = 1'b0;
         end
         REQ_PIXEL: begin
            // Pixels past the count limit are dropped, but a last mark still stores.
            if (acc_count < MAX_PIXELS) begin
               acc_sum = acc_sum + r.pixel;
               acc_count = acc_count + 1'b1;
            end
            if (r.is_last) begin
               if (r.code < TABLE_DEPTH) begin
                  levels[r.code] = (acc_count != 0) ? LEVEL_W'(acc_sum / acc_count) : '0;
                  occupied[r.code] = 1'b1;
               end
               acc_sum = '0;
               acc_count = '0;
            end
         end
         REQ_NORMALIZE: begin
            for (i = 0; i < TABLE_DEPTH; i++) begin
               if (occupied[i]) begin
                  if (!found) begin
                     lo = levels[i];
                     hi = levels[i];
                     found = 1'b1;
                  end else begin
                     if (levels[i] < lo) lo = levels[i];
                     if (levels[i] > hi) hi = levels[i];
                  end
               end
            end
            rep.kind = RSP_NORMALIZE;
            if (!found) begin
               rep.empty = 1'b1;
            end else if (hi == lo) begin
               rep.flat = 1'b1;
            end else begin
               for (i = 0; i < TABLE_DEPTH; i++) begin
                  if (occupied[i])
                     levels[i] = LEVEL_W'((int'(levels[i]) - lo) * MAX_LEVEL / (hi - lo));
               end
            end
            expected_replies.push_back(rep);
         end
         REQ_QUERY: begin
            // Ascending scan; only a strictly closer level replaces the current best.
            best = MAX_LEVEL;
            for (i = 0; i < TABLE_DEPTH; i++) begin
               if (occupied[i]) begin
                  if (!found) begin
                     rep.symbol = CODE_W'(i);
                     found = 1'b1;
                  end
                  d = int'(r.target) - int'(levels[i]);
                  if (d < 0) d = -d;
                  if (d < best) begin
                     best = d;
                     rep.symbol = CODE_W'(i);
                  end
               end
            end
            rep.kind = RSP_QUERY;
            rep.empty = !found;
            expected_replies.push_back(rep);
         end
      endcase
   endfunction

   function automatic void push_req(logic [REQ_TYPE_W-1:0] kind, logic [CODE_W-1:0] code,
                                    logic [LEVEL_W-1:0] pixel, logic is_last,
                                    logic [LEVEL_W-1:0] target);
      glyph_req_type r;
      r.kind = kind;
      r.code = code;
      r.pixel = pixel;
      r.is_last = is_last;
      r.target = target;
      pending_reqs.push_back(r);
      reqs_queued++;
   endfunction

   // Mostly complete glyphs and queries with random content, plus a little noise.
   function automatic void queue_random_traffic(int unsigned item_goal);
      int unsigned       queued;
      int unsigned       pick;
      int unsigned       npix;
      int unsigned       k;
      bit                extreme;
      logic [CODE_W-1:0] code;
      logic [LEVEL_W-1:0] pix;
      queued = 0;
      while (queued < item_goal) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            // Most glyphs land on a few codes so queries see rivals and overwrites.
            code = ($urandom_range(3) == 0) ? CODE_W'($urandom) : CODE_W'($urandom_range(15));
            npix = $urandom_range(6, 1);
            extreme = ($urandom_range(5) == 0);
            for (k = 0; k < npix; k++) begin
               pix = extreme ? {LEVEL_W{1'($urandom)}} : LEVEL_W'($urandom);
               push_req(REQ_PIXEL, code, pix, k == npix - 1, LEVEL_W'($urandom));
            end
            queued += npix;
         end else if (pick < 85) begin
            push_req(REQ_QUERY, CODE_W'($urandom), LEVEL_W'($urandom), 1'($urandom),
                     LEVEL_W'($urandom));
            queued++;
         end else if (pick < 91) begin
            push_req(REQ_NORMALIZE, CODE_W'($urandom), LEVEL_W'($urandom), 1'($urandom),
                     LEVEL_W'($urandom));
            queued++;
         end else if (pick < 94) begin
            push_req(REQ_CLEAR, CODE_W'($urandom), LEVEL_W'($urandom), 1'($urandom),
                     LEVEL_W'($urandom));
            queued++;
         end else begin
            // Noise: any request with every field random, broken glyphs included.
            push_req(REQ_TYPE_W'($urandom), CODE_W'($urandom), LEVEL_W'($urandom),
                     1'($urandom), LEVEL_W'($urandom));
            queued++;
         end
      end
   endfunction

   // Record each request transfer and feed the predictor.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         sent_count <= 0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            apply_request({req_ch.req_type, req_ch.symbol_code, req_ch.pixel_value,
                           req_ch.last_pixel, req_ch.target_level});
            sent_count <= sent_count + 1;
         end
      end
   end

   // Request driver: holds an offered item until its transfer, then maybe idles.
   always @(negedge clock) begin
      glyph_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.req_type <= nxt.kind;
            req_ch.symbol_code <= nxt.code;
            req_ch.pixel_value <= nxt.pixel;
            req_ch.last_pixel <= nxt.is_last;
            req_ch.target_level <= nxt.target;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, started once at a chosen request count.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles_left <= 0;
         hold_used <= 1'b0;
      end else if (!hold_used && sent_count == hold_at) begin
         hold_cycles_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_cycles_left != 0) begin
         hold_cycles_left <= hold_cycles_left - 1;
      end
   end

   // Reply ready with random stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (hold_cycles_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Reply checker: every transfer against the oldest expectation.
   always @(posedge clock) begin
      glyph_reply_type got;
      glyph_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.reply_kind, rsp_ch.match_symbol, rsp_ch.table_empty, rsp_ch.flat_range};
         if (expected_replies.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: reply with none expected: kind=%0d symbol=%0d empty=%0d flat=%0d",
                        $realtime, got.kind, got.symbol, got.empty, got.flat);
         end else begin
            want = expected_replies.pop_front();
            if (got.kind !== want.kind || got.symbol !== want.symbol ||
                got.empty !== want.empty || got.flat !== want.flat) begin
               error_count++;
               if (error_count <= 10)
                  $display({"%0t: reply mismatch: expected kind=%0d symbol=%0d empty=%0d ",
                            "flat=%0d, got kind=%0d symbol=%0d empty=%0d flat=%0d"},
                           $realtime, want.kind, want.symbol, want.empty, want.flat,
                           got.kind, got.symbol, got.empty, got.flat);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stimulus and verdict.
   initial begin
      int unsigned n;
      int unsigned phase;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_CLEAR;
      req_ch.symbol_code = '0;
      req_ch.pixel_value = '0;
      req_ch.last_pixel = 1'b0;
      req_ch.target_level = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reqs_queued = 0;
      hold_at = 32'hFFFF_FFFF;
      error_count = 0;
      cycle_count = 0;
      acc_sum = '0;
      acc_count = '0;
      for (n = 0; n < TABLE_DEPTH; n++) occupied[n] = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty table for query and normalize.
      push_req(REQ_QUERY, '0, '0, 1'b0, 8'd0);
      push_req(REQ_NORMALIZE, '0, '0, 1'b0, '0);
      // A single entry gives a flat range.
      push_req(REQ_PIXEL, 7'd0, 8'd255, 1'b1, '0);
      push_req(REQ_NORMALIZE, '0, '0, 1'b0, '0);
      // Extreme codes and levels, then queries at both ends and in the middle.
      push_req(REQ_PIXEL, 7'd127, 8'd0, 1'b0, 8'd255);
      push_req(REQ_PIXEL, 7'd127, 8'd0, 1'b1, 8'd255);
      push_req(REQ_QUERY, '0, '0, 1'b0, 8'd255);
      push_req(REQ_QUERY, '0, '0, 1'b0, 8'd0);
      push_req(REQ_QUERY, '0, '0, 1'b0, 8'd128);
      // Floor mean of several pixels, then a real rescale.
      push_req(REQ_PIXEL, 7'd5, 8'd10, 1'b0, '0);
      push_req(REQ_PIXEL, 7'd5, 8'd20, 1'b0, '0);
      push_req(REQ_PIXEL, 7'd5, 8'd31, 1'b1, '0);
      push_req(REQ_NORMALIZE, '0, '0, 1'b0, '0);
      push_req(REQ_QUERY, '0, '0, 1'b0, 8'd20);
      // A clear in the middle of a glyph keeps the accumulator.
      push_req(REQ_PIXEL, 7'd9, 8'd100, 1'b0, '0);
      push_req(REQ_CLEAR, '0, '0, 1'b0, '0);
      push_req(REQ_QUERY, '0, '0, 1'b0, 8'd77);
      push_req(REQ_PIXEL, 7'd9, 8'd50, 1'b1, '0);
      push_req(REQ_QUERY, '0, '0, 1'b0, 8'd200);
      // No entry closer than the full scale: the lowest valid code wins.
      push_req(REQ_CLEAR, '0, '0, 1'b0, '0);
      push_req(REQ_PIXEL, 7'd70, 8'd255, 1'b1, '0);
      push_req(REQ_PIXEL, 7'd64, 8'd255, 1'b1, '0);
      push_req(REQ_QUERY, '0, '0, 1'b0, 8'd0);
      push_req(REQ_NORMALIZE, '0, '0, 1'b0, '0);
      wait (pending_reqs.size() == 0);

      // Random traffic under each idling pattern.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               hold_at = reqs_queued + 30;
            end
            1: begin
               send_idle_pct = 54;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 54;
            end
            default: begin
               send_idle_pct = 13;
               rsp_stall_pct = 13;
            end
         endcase
         queue_random_traffic(106);
         wait (pending_reqs.size() == 0);
      end

      // Drain and let any trailing work settle.
      wait (pending_reqs.size() == 0 && !req_ch.valid);
      wait (expected_replies.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
